// ===== src/lmtg_pkg.sv =====
// Shared constants and types for the load monitor tier governor.
package lmtg_pkg;

  // Field widths
  localparam int LOAD_W   = 24;
  localparam int BUDGET_W = 24;
  localparam int LIMIT_W  = 16;
  localparam int TIER_W   = 2;

  // Load scale: 100 percent in 1/256 percent units
  localparam int SCALE_W    = 15;
  localparam int LOAD_SCALE = 25600;
  localparam int DIVIDEND_W = LOAD_W + SCALE_W;

  // Thresholds in 1/256 percent units
  localparam logic [LOAD_W-1:0] LOAD_MAX  = 24'hFFFFFF;
  localparam logic [LOAD_W-1:0] OVER_HIGH = 24'd20480;
  localparam logic [LOAD_W-1:0] OVER_LOW  = 24'd15360;
  localparam logic [LOAD_W-1:0] TIER_DOWN = 24'd17920;
  localparam logic [LOAD_W-1:0] TIER_UP   = 24'd10240;

  // Smoothing coefficient 0.1 as Q0.16
  localparam logic signed [14:0] SMOOTH_Q16 = 15'sd6554;
  localparam int PROD_W = LOAD_W + 1 + 15;

  // Tier codes
  localparam logic [TIER_W-1:0] TIER_ECO    = 2'd0;
  localparam logic [TIER_W-1:0] TIER_NORMAL = 2'd1;
  localparam logic [TIER_W-1:0] TIER_HIGH   = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_BUDGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLOAD_LIM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIER_DELAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_ADJUST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TIER  = 3'd4;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/load_monitor_tier_governor.sv =====
// Top level of the load monitor tier governor.
// Each input word carries one measured block duration in microseconds and yields
// one output word with the load (1/256 percent of the time budget, saturated),
// the smoothed load, the peak load, the sustained-overload flag, the quality tier
// and a tier-changed flag. An item passes from acceptance to result through the
// bit-serial divider (one quotient bit per cycle over the 39-bit scaled duration),
// a step that captures and saturates the quotient, the smoothing multiply and the
// state update. The state update waits while the previous result still sits
// unaccepted in the output register. A new word is accepted the cycle after the
// previous one has been written to the output register, even if that result is
// still waiting for out_tready, so a new word is taken only once the previous one
// is through. Configuration writes are taken every cycle; write registers only
// while no word is in flight.
module load_monitor_tier_governor #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,   // [23:0] duration_us
  // Output stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [79:0]                    out_tdata,  // [23:0] cpu_load, [47:24] average_load,
                                                     // [71:48] peak_load, [72] overloaded,
                                                     // [74:73] quality_tier, [75] tier_changed,
                                                     // [79:76] zero
  // Configuration write
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lmtg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]                    cfg_data
);
  import lmtg_pkg::*;

  localparam int CMP_W = (COUNTER_WIDTH > LIMIT_W) ? COUNTER_WIDTH : LIMIT_W;
  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

  // Sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  // Configuration registers
  logic [BUDGET_W-1:0] budget_r;
  logic [LIMIT_W-1:0]  olim_r;
  logic [LIMIT_W-1:0]  tdelay_r;
  logic                auto_r;
  logic [TIER_W-1:0]   target_r;

  // Governor state
  logic [1:0]               state_r, state_nxt;
  logic [LOAD_W-1:0]        load_r, load_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [LOAD_W-1:0]        smooth_r, smooth_nxt;
  logic [LOAD_W-1:0]        peak_r, peak_nxt;
  logic [COUNTER_WIDTH-1:0] orun_r, orun_nxt;
  logic                     oflag_r, oflag_nxt;
  logic [TIER_W-1:0]        tier_r, tier_nxt;
  logic [COUNTER_WIDTH-1:0] trun_r, trun_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [75:0]              out_data_r, out_data_nxt;

  // Divider hookup
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [BUDGET_W-1:0]   div_divisor;
  logic [DIVIDEND_W-1:0] div_quo;
  div_stat_t             div_stat;

  // Update-stage helpers
  logic signed [LOAD_W:0]     diff;
  logic signed [LOAD_W-1:0]   step;
  logic signed [LOAD_W+1:0]   avg_sum;
  logic [LOAD_W-1:0]          avg;
  logic [COUNTER_WIDTH-1:0]   orun_bump;
  logic [COUNTER_WIDTH-1:0]   trun_bump;
  logic [TIER_W-1:0]          tgt;
  logic [TIER_W-1:0]          want;
  logic                       changed;
  logic                       out_free;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= 24'd10667;
      olim_r   <= 16'd3;
      tdelay_r <= 16'd10;
      auto_r   <= 1'b1;
      target_r <= TIER_HIGH;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TIME_BUDGET:  budget_r <= cfg_data[BUDGET_W-1:0];
        REG_OVERLOAD_LIM: olim_r   <= cfg_data[LIMIT_W-1:0];
        REG_TIER_DELAY:   tdelay_r <= cfg_data[LIMIT_W-1:0];
        REG_AUTO_ADJUST:  auto_r   <= cfg_data[0];
        REG_TARGET_TIER:  target_r <= cfg_data[TIER_W-1:0];
        default: ;
      endcase
    end
  end

  // Scale duration to 1/256 percent and divide by the budget
  assign in_tready    = (state_r == ST_IDLE) && !div_stat.busy;
  assign div_start    = in_tvalid && in_tready;
  assign div_dividend = DIVIDEND_W'(in_tdata) * DIVIDEND_W'(LOAD_SCALE);
  assign div_divisor  = (budget_r == '0) ? BUDGET_W'(1) : budget_r;

  lmtg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // Smoothing step: floor(6554 * d / 65536) by arithmetic shift
  assign diff    = $signed({1'b0, load_r}) - $signed({1'b0, smooth_r});
  assign step    = LOAD_W'(prod_r >>> 16);
  assign avg_sum = $signed({2'b00, smooth_r}) + (LOAD_W+2)'(step);
  assign avg     = avg_sum[LOAD_W-1:0];

  assign orun_bump = (orun_r == CNT_MAX) ? orun_r : orun_r + 1'b1;
  assign trun_bump = (trun_r == CNT_MAX) ? trun_r : trun_r + 1'b1;
  assign tgt       = (target_r > TIER_HIGH) ? TIER_HIGH : target_r;
  assign out_free  = !out_valid_r || out_tready;

  // Wanted tier from the new average
  always_comb begin
    want = tier_r;
    if (avg > TIER_DOWN && tier_r != TIER_ECO) begin
      want = tier_r - 1'b1;
    end else if (avg < TIER_UP && tier_r != tgt) begin
      if (tier_r < tgt) begin
        want = tier_r + 1'b1;
      end
    end
  end

  // Sequencer and state update
  always_comb begin
    state_nxt     = state_r;
    load_nxt      = load_r;
    prod_nxt      = prod_r;
    smooth_nxt    = smooth_r;
    peak_nxt      = peak_r;
    orun_nxt      = orun_r;
    oflag_nxt     = oflag_r;
    tier_nxt      = tier_r;
    trun_nxt      = trun_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    changed       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (div_start) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          load_nxt  = (div_quo[DIVIDEND_W-1:LOAD_W] != '0) ? LOAD_MAX :
                      div_quo[LOAD_W-1:0];
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(diff) * PROD_W'(SMOOTH_Q16);
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          smooth_nxt = avg;
          if (load_r > peak_r) begin
            peak_nxt = load_r;
          end
          if (load_r > OVER_HIGH) begin
            orun_nxt = orun_bump;
            if (CMP_W'(orun_bump) >= CMP_W'(olim_r)) begin
              oflag_nxt = 1'b1;
            end
          end else begin
            orun_nxt = '0;
            if (load_r < OVER_LOW) begin
              oflag_nxt = 1'b0;
            end
          end
          if (auto_r) begin
            if (want != tier_r) begin
              trun_nxt = trun_bump;
              if (CMP_W'(trun_bump) >= CMP_W'(tdelay_r)) begin
                tier_nxt = want;
                trun_nxt = '0;
                changed  = 1'b1;
              end
            end else begin
              trun_nxt = '0;
            end
          end
          out_data_nxt  = {changed, tier_nxt, oflag_nxt, peak_nxt, avg, load_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Advance registers
  always_ff @(posedge clk) begin
    load_r     <= load_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      smooth_r    <= '0;
      peak_r      <= '0;
      orun_r      <= '0;
      oflag_r     <= 1'b0;
      tier_r      <= TIER_HIGH;
      trun_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      smooth_r    <= smooth_nxt;
      peak_r      <= peak_nxt;
      orun_r      <= orun_nxt;
      oflag_r     <= oflag_nxt;
      tier_r      <= tier_nxt;
      trun_r      <= trun_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_data_r};

endmodule

// ===== src/lmtg_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module lmtg_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [lmtg_pkg::DIVIDEND_W-1:0]     dividend,
  input  logic [lmtg_pkg::BUDGET_W-1:0]       divisor,
  output logic [lmtg_pkg::DIVIDEND_W-1:0]     quotient,
  output lmtg_pkg::div_stat_t                 stat
);
  import lmtg_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

  logic [BUDGET_W-1:0]   rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [BUDGET_W-1:0]   dsr_r, dsr_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [BUDGET_W:0]     trial;
  logic [BUDGET_W:0]     diff;
  logic                  fits;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start && !busy_r) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[BUDGET_W-1:0] : trial[BUDGET_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold datapath without reset, clear control
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== dv/load_monitor_tier_governor_tb.sv =====
// Self-checking stream testbench for the load monitor tier governor.
module load_monitor_tier_governor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmtg_pkg::*;

  localparam int CNT_W = 16;
  localparam int STALL_PCT = 34;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED [3] = '{3'd5, 3'd6, 3'd7};

  typedef struct packed {
    logic [LOAD_W-1:0] cpu_load;
    logic [LOAD_W-1:0] average_load;
    logic [LOAD_W-1:0] peak_load;
    logic              overloaded;
    logic [TIER_W-1:0] quality_tier;
    logic              tier_changed;
  } load_report_t;

  typedef enum {RG_LOW, RG_MID, RG_HIGH, RG_OVER, RG_WILD} load_regime_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;       // [23:0] duration_us
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;           // [23:0] cpu_load, [47:24] average_load,
                                    // [71:48] peak_load, [72] overloaded,
                                    // [74:73] quality_tier, [75] tier_changed
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [23:0]          cfg_data = '0;

  // Register shadow, reset values
  logic [BUDGET_W-1:0] budget_reg = 24'd10667;
  logic [LIMIT_W-1:0]  over_limit_reg = 16'd3;
  logic [LIMIT_W-1:0]  tier_delay_reg = 16'd10;
  logic                auto_reg = 1'b1;
  logic [TIER_W-1:0]   target_reg = TIER_HIGH;

  // Governor state mirror
  logic [LOAD_W-1:0] avg_state = '0;
  logic [LOAD_W-1:0] peak_state = '0;
  logic [CNT_W-1:0]  over_run = '0;
  logic              over_flag = 1'b0;
  logic [TIER_W-1:0] tier_state = TIER_HIGH;
  logic [CNT_W-1:0]  tier_streak = '0;

  logic [23:0]  pending_durations [$];
  load_report_t expected_reports [$];
  logic         in_taken = 1'b0;
  logic         calm = 1'b0;
  int           mismatch_count = 0;
  int           quiet_cycles = 0;

  load_monitor_tier_governor #(.COUNTER_WIDTH(CNT_W)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturating run counter
  function automatic logic [CNT_W-1:0] bump_run(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

  // Advance the governor mirror by one duration word and return its report
  function automatic load_report_t step_governor(input logic [23:0] dur);
    longint unsigned denom, quot;
    longint          diff, nudge, avg_next;
    logic [LOAD_W-1:0] load;
    logic [TIER_W-1:0] goal, want;
    load_report_t      r;
    denom = (budget_reg == 0) ? 1 : budget_reg;
    quot = (64'(dur) * LOAD_SCALE) / denom;
    load = (quot > LOAD_MAX) ? LOAD_MAX : quot[LOAD_W-1:0];

    // Smooth with floor shift, clamp to the load range
    diff = longint'({1'b0, load}) - longint'({1'b0, avg_state});
    nudge = (diff * 64'sd6554) >>> 16;
    avg_next = longint'({1'b0, avg_state}) + nudge;
    if (avg_next < 0) avg_next = 0;
    if (avg_next > longint'({1'b0, LOAD_MAX})) avg_next = longint'({1'b0, LOAD_MAX});
    avg_state = avg_next[LOAD_W-1:0];

    if (load > peak_state) peak_state = load;

    // Sustained overload with hysteresis
    if (load > OVER_HIGH) begin
      over_run = bump_run(over_run);
      if (over_run >= over_limit_reg) over_flag = 1'b1;
    end else begin
      over_run = '0;
      if (load < OVER_LOW) over_flag = 1'b0;
    end

    r.tier_changed = 1'b0;
    if (auto_reg) begin
      goal = (target_reg > TIER_HIGH) ? TIER_HIGH : target_reg;
      want = tier_state;
      if (avg_state > TIER_DOWN && tier_state != TIER_ECO) begin
        want = tier_state - 2'd1;
      end else if (avg_state < TIER_UP && tier_state != goal) begin
        if (tier_state < goal) want = tier_state + 2'd1;
      end
      if (want != tier_state) begin
        tier_streak = bump_run(tier_streak);
        if (tier_streak >= tier_delay_reg) begin
          tier_state = want;
          tier_streak = '0;
          r.tier_changed = 1'b1;
        end
      end else begin
        tier_streak = '0;
      end
    end

    r.cpu_load = load;
    r.average_load = avg_state;
    r.peak_load = peak_state;
    r.overloaded = over_flag;
    r.quality_tier = tier_state;
    return r;
  endfunction

  // Duration that lands near a load level of the chosen regime
  function automatic logic [23:0] pick_duration(input load_regime_t rg);
    longint unsigned eff, load_goal, dur;
    eff = (budget_reg == 0) ? 1 : budget_reg;
    case (rg)
      RG_LOW:  load_goal = $urandom_range(0, TIER_UP - 1);
      RG_MID:  load_goal = $urandom_range(TIER_UP, TIER_DOWN);
      RG_HIGH: load_goal = $urandom_range(TIER_DOWN + 1, OVER_HIGH);
      RG_OVER: load_goal = $urandom_range(OVER_HIGH + 1, 60000);
      default: load_goal = 0;
    endcase
    dur = load_goal * eff / LOAD_SCALE;
    if (rg == RG_WILD) dur = $urandom & 32'hFFFFFF;
    if (dur > LOAD_MAX) dur = LOAD_MAX;
    return dur[23:0];
  endfunction

  task automatic check_field(input string name, input logic [23:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      if (mismatch_count < 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Input side: take accepted words into the mirror
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      expected_reports.push_back(step_governor(in_tdata));
      void'(pending_durations.pop_front());
    end
  end

  // Input driver: hold until taken, otherwise offer the next word or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (pending_durations.size() != 0 && (calm || $urandom_range(0, 99) >= STALL_PCT)) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_durations[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output backpressure
  always @(negedge clk) begin
    out_tready <= rst_n && (calm || $urandom_range(0, 99) >= STALL_PCT);
  end

  // Output monitor: compare each word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: output word with nothing expected: %h", $realtime, out_tdata);
        mismatch_count++;
      end else begin
        load_report_t e;
        e = expected_reports.pop_front();
        check_field("cpu_load", e.cpu_load, out_tdata[23:0]);
        check_field("average_load", e.average_load, out_tdata[47:24]);
        check_field("peak_load", e.peak_load, out_tdata[71:48]);
        check_field("overloaded", e.overloaded, out_tdata[72]);
        check_field("quality_tier", e.quality_tier, out_tdata[74:73]);
        check_field("tier_changed", e.tier_changed, out_tdata[75]);
      end
    end
  end

  // Register shadow follows accepted writes; unmapped indexes drop
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIME_BUDGET:  budget_reg <= cfg_data;
        REG_OVERLOAD_LIM: over_limit_reg <= cfg_data[15:0];
        REG_TIER_DELAY:   tier_delay_reg <= cfg_data[15:0];
        REG_AUTO_ADJUST:  auto_reg <= cfg_data[0];
        REG_TARGET_TIER:  target_reg <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $realtime);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input logic [23:0] budget, olim, delay, auto_on, target);
    write_reg(REG_TIME_BUDGET, budget);
    write_reg(REG_OVERLOAD_LIM, olim);
    write_reg(REG_TIER_DELAY, delay);
    write_reg(REG_AUTO_ADJUST, auto_on);
    write_reg(REG_TARGET_TIER, target);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_durations.size() != 0 || expected_reports.size() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  // Queue runs of similar load so the average and tier machine settle
  task automatic queue_runs(input int n_items);
    int           queued;
    int           run_len;
    int           pick;
    load_regime_t rg;
    queued = 0;
    while (queued < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) rg = RG_LOW;
      else if (pick < 45) rg = RG_MID;
      else if (pick < 60) rg = RG_HIGH;
      else if (pick < 90) rg = RG_OVER;
      else rg = RG_WILD;
      run_len = (rg == RG_WILD) ? $urandom_range(1, 3) : $urandom_range(1, 30);
      repeat (run_len) begin
        pending_durations.push_back(pick_duration(rg));
        queued++;
      end
    end
  endtask

  initial begin
    logic [23:0] rnd_budget;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Unit budget scale: load equals duration, so thresholds hit exactly
    apply_settings(24'd25600, 24'd0, 24'd1, 24'd1, 24'd3);
    pending_durations = '{24'd0, 24'hFFFFFF, 24'd20480, 24'd15360, 24'd15359,
                          24'd20481, 24'd17920, 24'd17921, 24'd10239, 24'd10240,
                          24'd1, 24'h800000, 24'h7FFFFF, 24'h555555, 24'hAAAAAA};
    wait_drained();

    // Zero budget acts as one: saturation edge
    apply_settings(24'd0, 24'd3, 24'd2, 24'd1, 24'd2);
    pending_durations = '{24'd0, 24'd655, 24'd656, 24'hFFFFFF};
    wait_drained();

    // Fixed settings, extremes among them
    apply_settings(24'd10667, 24'd3, 24'd10, 24'd1, 24'd2);
    queue_runs(180);
    wait_drained();

    calm = 1'b1;
    apply_settings(24'd25600, 24'd1, 24'd1, 24'd1, 24'd1);
    queue_runs(120);
    wait_drained();
    calm = 1'b0;

    apply_settings(24'd1, 24'd65535, 24'd65535, 24'd1, 24'd0);
    queue_runs(60);
    wait_drained();

    apply_settings(24'hFFFFFF, 24'd0, 24'd0, 24'd1, 24'd3);
    queue_runs(120);
    wait_drained();

    apply_settings(24'd5000, 24'd2, 24'd4, 24'd0, 24'd2);
    write_reg(REG_UNMAPPED[0], 24'hFFFFFF);
    write_reg(REG_UNMAPPED[1], 24'h000000);
    write_reg(REG_UNMAPPED[2], 24'hA5A5A5);
    @(negedge clk);
    cfg_valid <= 1'b0;
    queue_runs(100);
    wait_drained();

    // Random settings
    repeat (5) begin
      case ($urandom_range(0, 3))
        0: rnd_budget = $urandom_range(1, 100);
        1: rnd_budget = $urandom_range(1000, 30000);
        2: rnd_budget = $urandom_range(30000, 2000000);
        default: rnd_budget = $urandom;
      endcase
      apply_settings(rnd_budget, $urandom_range(0, 6), $urandom_range(0, 12),
                     ($urandom_range(0, 4) != 0) ? 24'hFFFFFF : 24'hFFFFFE,
                     $urandom_range(0, 3));
      write_reg(REG_UNMAPPED[$urandom_range(0, 2)], $urandom);
      @(negedge clk);
      cfg_valid <= 1'b0;
      queue_runs(110);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_reports.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
